// ----- rtl/fifo_queue_with_match_remove_macros.svh -----
// Assertion helpers shared by the RTL. Both sample on i_clk and are
// switched off while i_rst_n is low.
`ifndef FIFO_QUEUE_WITH_MATCH_REMOVE_MACROS_SVH
`define FIFO_QUEUE_WITH_MATCH_REMOVE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FQMR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FQMR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/fqmr_pkg.sv -----
`default_nettype none

package fqmr_pkg;

    // Widths of the value fields on the ports.
    localparam int DATA_BITS = 32;
    // Widest stored value that a configuration may ask for.
    localparam int MAX_VALUE_BITS = 64;

    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_VALUE_BITS  = 32;

    typedef enum logic [1:0] {
        FUNC_PUSH   = 2'd0,
        FUNC_POP    = 2'd1,
        FUNC_REMOVE = 2'd2,
        FUNC_LIST   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } t_status;

    // Controls from the sequencer to the entry store.
    typedef struct packed {
        logic we;
        logic re;
    } t_mem_ctl;

    // One result transaction as produced by the sequencer.
    typedef struct packed {
        t_status               status;
        logic                  removed;
        logic [DATA_BITS-1:0]  entry_value;
        logic                  entry_valid;
        logic [DATA_BITS-1:0]  front_value;
        logic                  queue_empty;
        logic                  last;
    } t_result;

endpackage

`default_nettype wire

// ----- rtl/fqmr_store.sv -----
`default_nettype none

module fqmr_store #(
    parameter int QUEUE_DEPTH = fqmr_pkg::DEF_QUEUE_DEPTH,
    parameter int VALUE_BITS  = fqmr_pkg::DEF_VALUE_BITS
) (
    input  wire                              i_clk,
    input  fqmr_pkg::t_mem_ctl               i_ctl,
    input  wire  [$clog2(QUEUE_DEPTH)-1:0]   i_waddr,
    input  wire  [VALUE_BITS-1:0]            i_wdata,
    input  wire  [$clog2(QUEUE_DEPTH)-1:0]   i_raddr,
    output logic [VALUE_BITS-1:0]            o_rdata
);
    import fqmr_pkg::*;

    // Entry store: one write and one registered read per cycle.
    logic [VALUE_BITS-1:0] r_mem [QUEUE_DEPTH];
    logic [VALUE_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_ctl.re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- rtl/fqmr_seq.sv -----
`default_nettype none
`include "fifo_queue_with_match_remove_macros.svh"

module fqmr_seq #(
    parameter int QUEUE_DEPTH = fqmr_pkg::DEF_QUEUE_DEPTH,
    parameter int VALUE_BITS  = fqmr_pkg::DEF_VALUE_BITS
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_valid,
    output logic                               o_ready,
    input  fqmr_pkg::t_func                    i_func,
    input  wire  [fqmr_pkg::DATA_BITS-1:0]     i_data,
    output logic                               o_res_valid,
    output fqmr_pkg::t_result                  o_res,
    input  wire                                i_res_ready,
    output fqmr_pkg::t_mem_ctl                 o_mem_ctl,
    output logic [$clog2(QUEUE_DEPTH)-1:0]     o_waddr,
    output logic [VALUE_BITS-1:0]              o_wdata,
    output logic [$clog2(QUEUE_DEPTH)-1:0]     o_raddr,
    input  wire  [VALUE_BITS-1:0]              i_rdata
);
    import fqmr_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_RD   = 8'b0000_0010,
        S_CMP  = 8'b0000_0100,
        S_SHR  = 8'b0000_1000,
        S_SHW  = 8'b0001_0000,
        S_EMIT = 8'b0010_0000,
        S_LRD  = 8'b0100_0000,
        S_LEM  = 8'b1000_0000
    } t_state;

    t_state                r_state, n_state;
    logic [CW-1:0]         r_count, n_count;
    logic [CW-1:0]         r_idx, n_idx;
    logic [VALUE_BITS-1:0] r_key, n_key;
    logic [VALUE_BITS-1:0] r_front, n_front;
    logic [VALUE_BITS-1:0] r_eval, n_eval;
    logic                  r_evalid, n_evalid;
    logic                  r_removed, n_removed;
    t_status               r_status, n_status;

    logic [MAX_VALUE_BITS-1:0] in_wide;
    logic [VALUE_BITS-1:0]     v_in;
    logic [MAX_VALUE_BITS-1:0] front_wide, eval_wide, rdata_wide;
    logic [CW-1:0]             idx_inc, idx_dec;
    logic                      key_hit;
    logic                      list_last;
    logic                      full_push;
    logic                      idx_held;

    assign in_wide    = MAX_VALUE_BITS'(i_data);
    assign v_in       = in_wide[VALUE_BITS-1:0];
    assign front_wide = MAX_VALUE_BITS'(r_front);
    assign eval_wide  = MAX_VALUE_BITS'(r_eval);
    assign rdata_wide = MAX_VALUE_BITS'(i_rdata);
    assign idx_inc    = CW'(r_idx + CW'(1));
    assign idx_dec    = CW'(r_idx - CW'(1));
    // The one shared comparator used by the removal scan.
    assign key_hit    = (i_rdata == r_key);
    assign list_last  = (idx_inc == r_count);
    assign full_push  = i_valid && o_ready && (i_func == FUNC_PUSH) &&
                        (r_count == CW'(QUEUE_DEPTH));
    assign idx_held   = (r_idx != '0) && (r_idx < r_count);

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_key     = r_key;
        n_front   = r_front;
        n_eval    = r_eval;
        n_evalid  = r_evalid;
        n_removed = r_removed;
        n_status  = r_status;

        o_ready     = 1'b0;
        o_mem_ctl   = '0;
        o_waddr     = idx_dec[AW-1:0];
        o_wdata     = i_rdata;
        o_raddr     = r_idx[AW-1:0];
        o_res_valid = 1'b0;

        o_res.status      = r_status;
        o_res.removed     = r_removed;
        o_res.entry_value = eval_wide[DATA_BITS-1:0];
        o_res.entry_valid = r_evalid;
        o_res.front_value = (r_count == '0) ? '0 : front_wide[DATA_BITS-1:0];
        o_res.queue_empty = (r_count == '0);
        o_res.last        = 1'b1;

        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_removed = 1'b0;
                    n_eval    = '0;
                    n_evalid  = 1'b0;
                    n_status  = STAT_OK;
                    n_key     = v_in;
                    n_idx     = '0;
                    n_state   = S_EMIT;
                    unique case (i_func)
                        FUNC_PUSH: begin
                            if (r_count == CW'(QUEUE_DEPTH)) begin
                                n_status = STAT_FULL;
                            end else begin
                                o_mem_ctl.we = 1'b1;
                                o_waddr      = r_count[AW-1:0];
                                o_wdata      = v_in;
                                if (r_count == '0) begin
                                    n_front = v_in;
                                end
                                n_count = CW'(r_count + CW'(1));
                            end
                        end
                        FUNC_POP: begin
                            if (r_count == '0) begin
                                n_status = STAT_EMPTY;
                            end else begin
                                n_eval   = r_front;
                                n_evalid = 1'b1;
                                n_idx    = CW'(1);
                                n_state  = S_SHR;
                            end
                        end
                        FUNC_REMOVE: begin
                            if (r_count != '0) begin
                                n_state = S_RD;
                            end
                        end
                        FUNC_LIST: begin
                            if (r_count != '0) begin
                                n_state = S_LRD;
                            end
                        end
                        default: begin
                            n_state = S_EMIT;
                        end
                    endcase
                end
            end
            S_RD: begin
                o_mem_ctl.re = 1'b1;
                n_state      = S_CMP;
            end
            S_CMP: begin
                n_idx = idx_inc;
                if (key_hit) begin
                    n_removed = 1'b1;
                    n_state   = S_SHR;
                end else if (idx_inc == r_count) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_RD;
                end
            end
            S_SHR: begin
                if (r_idx >= r_count) begin
                    n_count = CW'(r_count - CW'(1));
                    n_state = S_EMIT;
                end else begin
                    o_mem_ctl.re = 1'b1;
                    n_state      = S_SHW;
                end
            end
            S_SHW: begin
                o_mem_ctl.we = 1'b1;
                if (idx_dec == '0) begin
                    n_front = i_rdata;
                end
                n_idx   = idx_inc;
                n_state = S_SHR;
            end
            S_EMIT: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            S_LRD: begin
                o_mem_ctl.re = 1'b1;
                n_state      = S_LEM;
            end
            S_LEM: begin
                o_res_valid       = 1'b1;
                o_res.status      = STAT_OK;
                o_res.removed     = 1'b0;
                o_res.entry_value = rdata_wide[DATA_BITS-1:0];
                o_res.entry_valid = 1'b1;
                o_res.last        = list_last;
                if (i_res_ready) begin
                    if (list_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = idx_inc;
                        n_state = S_LRD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_idx     <= n_idx;
        r_key     <= n_key;
        r_front   <= n_front;
        r_eval    <= n_eval;
        r_evalid  <= n_evalid;
        r_removed <= n_removed;
        r_status  <= n_status;
    end

    `FQMR_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CW'(QUEUE_DEPTH), "count above depth")
    `FQMR_ASSERT_NEXT(a_full_push_keeps, full_push, $stable(r_count), "full push moved count")
    `FQMR_ASSERT_NOW(a_shift_index, r_state == S_SHW, idx_held, "shift outside held entries")
    `FQMR_ASSERT_NOW(a_list_index, r_state == S_LEM, r_idx < r_count, "list beyond back entry")

endmodule

`default_nettype wire

// ----- rtl/fifo_queue_with_match_remove.sv -----
// Push is accepted in the idle state, forms its result in the emit state, then waits in the
// output register; a new transaction is taken only after the last one delivered all its results.
// Pop and remove walk the entry store through its single read port: a pop or a hit shifts
// each later entry with a read state and a write state, a removal scan reads and compares
// one entry at a time, and list reads each entry before emitting its result. Synchronous
// active-low reset empties the queue; stored entries are not cleared.
`default_nettype none

module fifo_queue_with_match_remove #(
    parameter int QUEUE_DEPTH = fqmr_pkg::DEF_QUEUE_DEPTH,
    parameter int VALUE_BITS  = fqmr_pkg::DEF_VALUE_BITS
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // Input channel.
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [31:0] i_s_tdata,   // [31:0] data_value
    input  wire  [1:0]  i_s_tuser,   // [1:0] func
    // Result channel.
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [63:0] o_m_tdata,   // [31:0] entry_value, [63:32] front_value
    output logic [4:0]  o_m_tuser,   // [1:0] status, [2] removed, [3] entry_valid, [4] queue_empty
    output logic        o_m_tlast    // last result of the input transaction
);
    import fqmr_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);

    t_mem_ctl              mem_ctl;
    logic [AW-1:0]         mem_waddr, mem_raddr;
    logic [VALUE_BITS-1:0] mem_wdata, mem_rdata;
    logic                  res_valid, res_ready;
    t_result               res;

    // Output register: a finished result waits here while the sequencer is
    // free to form the next one.
    logic    r_out_valid;
    t_result r_out;

    // The sequencer owns all queue state and drives the store. It only takes
    // a new transaction once the previous one has delivered all its results.
    fqmr_seq #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .VALUE_BITS  (VALUE_BITS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_func      (t_func'(i_s_tuser)),
        .i_data      (i_s_tdata),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (res_ready),
        .o_mem_ctl   (mem_ctl),
        .o_waddr     (mem_waddr),
        .o_wdata     (mem_wdata),
        .o_raddr     (mem_raddr),
        .i_rdata     (mem_rdata)
    );

    fqmr_store #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .VALUE_BITS  (VALUE_BITS)
    ) u_store (
        .i_clk   (i_clk),
        .i_ctl   (mem_ctl),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // The register can take a new result when empty or when being drained.
    assign res_ready = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out.front_value, r_out.entry_value};
    assign o_m_tuser  = {r_out.queue_empty, r_out.entry_valid, r_out.removed, r_out.status};
    assign o_m_tlast  = r_out.last;

endmodule

`default_nettype wire

// ----- sim/fqmr_checker.sv -----
`timescale 1ns / 100ps
`default_nettype none

module fqmr_checker #(
    parameter int QUEUE_DEPTH = fqmr_pkg::DEF_QUEUE_DEPTH
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    input  wire         i_s_tready,
    input  wire  [31:0] i_s_tdata,   // [31:0] data_value
    input  wire  [1:0]  i_s_tuser,   // [1:0] func
    input  wire         i_m_tvalid,
    input  wire         i_m_tready,
    input  wire  [63:0] i_m_tdata,   // [31:0] entry_value, [63:32] front_value
    input  wire  [4:0]  i_m_tuser,   // [1:0] status, [2] removed, [3] entry_valid, [4] queue_empty
    input  wire         i_m_tlast,
    input  wire         i_end_check,
    output int          o_fail_count,
    output int          o_outstanding,
    output int          o_results_checked
);
    import fqmr_pkg::*;

    logic [31:0] held_handles[$];
    t_result     expected_results[$];
    int          fail_count = 0;
    int          results_checked = 0;
    bit          end_seen = 1'b0;

    assign o_fail_count      = fail_count;
    assign o_results_checked = results_checked;

    task automatic report_failure(input string msg);
        $display("[%0t] ERROR: %s", $time, msg);
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_failure($sformatf("result %0d: %s is 0x%08h, expected 0x%08h",
                                     results_checked, name, got, want));
        end
    endtask

    // Applies one operation to the model queue and appends the results it causes.
    task automatic apply_queue_operation(input t_func op, input logic [31:0] value);
        t_result res;
        int      hit;
        res        = '0;
        res.status = STAT_OK;
        res.last   = 1'b1;
        hit        = -1;
        case (op)
            FUNC_PUSH: begin
                if (held_handles.size() >= QUEUE_DEPTH) begin
                    res.status = STAT_FULL;
                end else begin
                    held_handles.push_back(value);
                end
            end
            FUNC_POP: begin
                if (held_handles.size() == 0) begin
                    res.status = STAT_EMPTY;
                end else begin
                    res.entry_value = held_handles.pop_front();
                    res.entry_valid = 1'b1;
                end
            end
            FUNC_REMOVE: begin
                for (int i = 0; i < held_handles.size(); i++) begin
                    if (held_handles[i] == value) begin
                        hit = i;
                        break;
                    end
                end
                if (hit >= 0) begin
                    held_handles.delete(hit);
                    res.removed = 1'b1;
                end
            end
            default: begin
                // A listing of a non-empty queue gives one result per entry.
                for (int i = 0; i < held_handles.size(); i++) begin
                    res.entry_value = held_handles[i];
                    res.entry_valid = 1'b1;
                    res.last        = (i == held_handles.size() - 1);
                    res.front_value = held_handles[0];
                    res.queue_empty = 1'b0;
                    expected_results.push_back(res);
                end
            end
        endcase
        if (op != FUNC_LIST || held_handles.size() == 0) begin
            res.front_value = (held_handles.size() != 0) ? held_handles[0] : '0;
            res.queue_empty = (held_handles.size() == 0);
            expected_results.push_back(res);
        end
    endtask

    task automatic compare_result();
        t_result want;
        if (expected_results.size() == 0) begin
            report_failure($sformatf("result with nothing expected: tdata 0x%016h tuser 0x%02h",
                                     i_m_tdata, i_m_tuser));
        end else begin
            want = expected_results.pop_front();
            check_field("status",      32'(i_m_tuser[1:0]), 32'(want.status));
            check_field("removed",     32'(i_m_tuser[2]),   32'(want.removed));
            check_field("entry_value", i_m_tdata[31:0],     want.entry_value);
            check_field("entry_valid", 32'(i_m_tuser[3]),   32'(want.entry_valid));
            check_field("front_value", i_m_tdata[63:32],    want.front_value);
            check_field("queue_empty", 32'(i_m_tuser[4]),   32'(want.queue_empty));
            check_field("last",        32'(i_m_tlast),      32'(want.last));
        end
        results_checked++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_m_tvalid && i_m_tready) begin
                compare_result();
            end
            if (i_s_tvalid && i_s_tready) begin
                apply_queue_operation(t_func'(i_s_tuser), i_s_tdata);
            end
            if (i_end_check && !end_seen) begin
                end_seen = 1'b1;
                if (expected_results.size() != 0) begin
                    report_failure($sformatf("%0d expected results never arrived",
                                             expected_results.size()));
                end
            end
        end
        o_outstanding <= expected_results.size();
    end

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps
`default_nettype none

// Stimulus and verdict for the queue with remove-by-value. The checker beside
// the block watches both channels, keeps its own model of the queue and
// compares every result transaction; this module only drives transactions,
// applies back-pressure and decides the outcome.
module testbench;
    import fqmr_pkg::*;

    localparam int RANDOM_ITEMS = 360;
    // The last stretch of the run is sent and received without any idling.
    localparam int QUIET_ITEMS  = 60;

    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_MIXED
    } t_mix;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;   // [31:0] data_value
    logic [1:0]  s_tuser = '0;   // [1:0] func
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;        // [31:0] entry_value, [63:32] front_value
    logic [4:0]  m_tuser;        // [1:0] status, [2] removed, [3] entry_valid, [4] queue_empty
    logic        m_tlast;
    logic        end_check = 1'b0;

    int          fail_count;
    int          outstanding;
    int          results_checked;

    // Recently pushed handles, so that removals and duplicate pushes hit often.
    logic [31:0] recent_pushes[$];
    int          op_count[4] = '{0, 0, 0, 0};
    bit          quiet = 1'b0;
    int          ready_hold = 0;

    fifo_queue_with_match_remove i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast)
    );

    fqmr_checker i_checker (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_s_tvalid        (s_tvalid),
        .i_s_tready        (s_tready),
        .i_s_tdata         (s_tdata),
        .i_s_tuser         (s_tuser),
        .i_m_tvalid        (m_tvalid),
        .i_m_tready        (m_tready),
        .i_m_tdata         (m_tdata),
        .i_m_tuser         (m_tuser),
        .i_m_tlast         (m_tlast),
        .i_end_check       (end_check),
        .o_fail_count      (fail_count),
        .o_outstanding     (outstanding),
        .o_results_checked (results_checked)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    // Receiver back-pressure: tready drops in random bursts, and stays high once
    // the quiet stretch has begun.
    always @(posedge clk) begin
        if (quiet) begin
            m_tready <= 1'b1;
        end else if (ready_hold > 0) begin
            ready_hold--;
        end else if (m_tready && $urandom_range(0, 5) == 0) begin
            m_tready   <= 1'b0;
            ready_hold = $urandom_range(0, 18);
        end else if (!m_tready) begin
            m_tready   <= 1'b1;
            ready_hold = $urandom_range(0, 30);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Offers one transaction, now and then after a random idle burst unless the run is in
    // its quiet stretch, and returns right after the edge that accepted it.
    // tvalid is left high so that a following transaction follows back to back.
    task automatic send_item(input t_func op, input logic [31:0] value);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= value;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        op_count[op]++;
        if (op == FUNC_PUSH) begin
            recent_pushes.push_back(value);
            if (recent_pushes.size() > 16) begin
                void'(recent_pushes.pop_front());
            end
        end
    endtask

    initial begin
        int          sent;
        int          span;
        int          roll;
        bit          first_episode;
        bit          pressure_done;
        t_mix        mix;
        t_func       op;
        logic [31:0] value;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening: operations on an empty queue, the extreme handle
        // values, a duplicate handle, removals at the front, in the middle
        // and at the back, a removal that misses, and a pop back to empty.
        send_item(FUNC_LIST,   $urandom);
        send_item(FUNC_POP,    $urandom);
        send_item(FUNC_REMOVE, 32'h0000_0000);
        send_item(FUNC_PUSH,   32'h0000_0000);
        send_item(FUNC_PUSH,   32'hFFFF_FFFF);
        send_item(FUNC_PUSH,   32'h5555_5555);
        send_item(FUNC_PUSH,   32'hAAAA_AAAA);
        send_item(FUNC_PUSH,   32'h5555_5555);
        send_item(FUNC_LIST,   32'hFFFF_FFFF);
        // Only the first of the two equal handles should go.
        send_item(FUNC_REMOVE, 32'h5555_5555);
        send_item(FUNC_LIST,   32'h0000_0000);
        send_item(FUNC_REMOVE, 32'h1234_5678);
        send_item(FUNC_REMOVE, 32'h0000_0000);
        send_item(FUNC_REMOVE, 32'h5555_5555);
        send_item(FUNC_LIST,   $urandom);
        send_item(FUNC_POP,    $urandom);
        send_item(FUNC_POP,    $urandom);
        send_item(FUNC_POP,    $urandom);
        send_item(FUNC_LIST,   $urandom);

        // Random part in episodes: filling episodes drive the queue to its
        // limit and beyond, draining ones take it back to empty, mixed ones
        // wander in between. The first episode always fills.
        sent          = 0;
        first_episode = 1'b1;
        pressure_done = 1'b0;
        while (sent < RANDOM_ITEMS) begin
            mix  = first_episode ? MIX_FILL : t_mix'($urandom_range(0, 2));
            span = first_episode ? 26 : $urandom_range(8, 30);
            first_episode = 1'b0;
            for (int k = 0; k < span && sent < RANDOM_ITEMS; k++) begin
                quiet = (sent >= RANDOM_ITEMS - QUIET_ITEMS);
                // Halfway through, hold the sender until every result is in.
                if (!pressure_done && sent >= RANDOM_ITEMS / 2) begin
                    s_tvalid <= 1'b0;
                    @(posedge clk);
                    while (outstanding != 0) @(posedge clk);
                    pressure_done = 1'b1;
                end
                roll = $urandom_range(0, 99);
                case (mix)
                    MIX_FILL:  op = (roll < 75) ? FUNC_PUSH : (roll < 80) ? FUNC_POP :
                                    (roll < 90) ? FUNC_REMOVE : FUNC_LIST;
                    MIX_DRAIN: op = (roll < 10) ? FUNC_PUSH : (roll < 65) ? FUNC_POP :
                                    (roll < 90) ? FUNC_REMOVE : FUNC_LIST;
                    default:   op = (roll < 35) ? FUNC_PUSH : (roll < 60) ? FUNC_POP :
                                    (roll < 85) ? FUNC_REMOVE : FUNC_LIST;
                endcase
                roll  = $urandom_range(0, 99);
                value = $urandom;
                if (op == FUNC_PUSH && recent_pushes.size() != 0 && roll < 25) begin
                    value = recent_pushes[$urandom_range(0, recent_pushes.size() - 1)];
                end else if (op == FUNC_PUSH && roll < 35) begin
                    value = (roll < 30) ? 32'h0000_0000 : 32'hFFFF_FFFF;
                end else if (op == FUNC_REMOVE && recent_pushes.size() != 0 && roll < 75) begin
                    value = recent_pushes[$urandom_range(0, recent_pushes.size() - 1)];
                end
                send_item(op, value);
                sent++;
            end
        end
        s_tvalid <= 1'b0;

        // Drain, then give the block time to finish any trailing shift work.
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        end_check <= 1'b1;
        repeat (2) @(posedge clk);

        $display("Run: %0d sent (%0d push, %0d pop, %0d remove, %0d list), %0d results checked.",
                 op_count[FUNC_PUSH] + op_count[FUNC_POP] + op_count[FUNC_REMOVE] +
                 op_count[FUNC_LIST], op_count[FUNC_PUSH], op_count[FUNC_POP],
                 op_count[FUNC_REMOVE], op_count[FUNC_LIST], results_checked);
        $display("Both channels idled in random bursts; the queue was taken to full and to empty.");
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #15_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
